@@ rtl/core/jss_pkg.sv @@
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants of the Jacobi stencil sweep unit: configuration
// register map, register widths and reset values, and the per-cell tag.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int GRID_SIZE_WIDTH = 11;
  localparam int THRESHOLD_WIDTH = 31;
  localparam int CFG_DATA_WIDTH  = 31;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int MIN_GRID        = 3;

  localparam logic [GRID_SIZE_WIDTH-1:0] GRID_SIZE_RESET = 11'd1024;
  localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 31'd655;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_GRID_SIZE = 4'd0,
    REG_THRESHOLD = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic first;
    logic last;
  } cell_tag_t;

endpackage

@@ rtl/core/jss_stream_ifs.sv @@
// ----------------------------------------------------------------------------
// jss stream interfaces
// Valid/ready channels of the sweep unit: old grid cells in, stencil results
// out.
// ----------------------------------------------------------------------------
interface jss_cell_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface jss_result_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] new_value;
  logic                          cell_converged;
  logic                          last_of_sweep;
  logic                          sweep_converged;

  modport source (output valid, output new_value, output cell_converged,
                  output last_of_sweep, output sweep_converged, input ready);
  modport sink   (input valid, input new_value, input cell_converged,
                  input last_of_sweep, input sweep_converged, output ready);
endinterface

@@ rtl/core/jss_line_buffer.sv @@
// ----------------------------------------------------------------------------
// jss_line_buffer
// Two row memories holding the two previous grid rows. Reads are registered
// and prefetched at the column of the next cell; the upper row takes the
// middle row's old value when the middle row takes the new cell.
// ----------------------------------------------------------------------------
module jss_line_buffer #(
  parameter int MAX_GRID    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic [$clog2(MAX_GRID)-1:0]          rd_col,
  input  logic                                 wr_en,
  input  logic [$clog2(MAX_GRID)-1:0]          wr_col,
  input  logic signed [VALUE_WIDTH-1:0]        wr_data,
  output logic signed [VALUE_WIDTH-1:0]        north,
  output logic signed [VALUE_WIDTH-1:0]        center,
  output logic signed [VALUE_WIDTH-1:0]        east
);

  localparam int AW = $clog2(MAX_GRID);

  logic signed [VALUE_WIDTH-1:0] upper_mem  [MAX_GRID];
  logic signed [VALUE_WIDTH-1:0] middle_mem [MAX_GRID];
  logic [AW-1:0]                 east_col;

  assign east_col = (rd_col == AW'(MAX_GRID - 1)) ? '0 : rd_col + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_col]  <= center;
      middle_mem[wr_col] <= wr_data;
    end
    north  <= upper_mem[rd_col];
    center <= middle_mem[rd_col];
    east   <= middle_mem[east_col];
  end

endmodule

@@ rtl/core/jss_stencil_calc.sv @@
// ----------------------------------------------------------------------------
// jss_stencil_calc
// Two-stage result path: neighbour sum register, then average, absolute
// change, threshold compare and sweep convergence into the result register.
// ----------------------------------------------------------------------------
module jss_stencil_calc #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  output logic                                      ready,
  input  logic signed [VALUE_WIDTH+1:0]             sum,
  input  logic signed [VALUE_WIDTH-1:0]             center,
  input  jss_pkg::cell_tag_t                        tag,
  input  logic [jss_pkg::THRESHOLD_WIDTH-1:0]       threshold,
  jss_result_if.source                              results
);

  localparam int SW = VALUE_WIDTH + 2;
  localparam int DW = VALUE_WIDTH + 1;
  localparam int CW = (DW > jss_pkg::THRESHOLD_WIDTH) ? DW : jss_pkg::THRESHOLD_WIDTH;

  logic                          a_valid;
  logic signed [SW-1:0]          a_sum;
  logic signed [VALUE_WIDTH-1:0] a_center;
  jss_pkg::cell_tag_t            a_tag;
  logic                          all_converged;

  logic                          b_free;
  logic                          advance;
  logic signed [SW-1:0]          quarter;
  logic signed [VALUE_WIDTH-1:0] avg;
  logic signed [DW-1:0]          delta;
  logic [DW-1:0]                 mag;
  logic                          ok;
  logic                          acc_start;
  logic                          acc_next;

  assign b_free  = !results.valid || results.ready;
  assign ready   = !a_valid || b_free;
  assign advance = a_valid && b_free;

  // floor of the sum over four
  assign quarter   = a_sum >>> 2;
  assign avg       = quarter[VALUE_WIDTH-1:0];
  assign delta     = DW'(avg) - DW'(a_center);
  assign mag       = delta[DW-1] ? DW'(-delta) : DW'(delta);
  assign ok        = CW'(mag) <= CW'(threshold);
  assign acc_start = a_tag.first ? 1'b1 : all_converged;
  assign acc_next  = acc_start && ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      results.valid <= 1'b0;
      all_converged <= 1'b1;
    end else begin
      if (ready) begin
        a_valid <= load;
      end
      if (b_free) begin
        results.valid <= a_valid;
      end
      if (advance) begin
        all_converged <= acc_next;
      end
    end
    if (ready && load) begin
      a_sum    <= sum;
      a_center <= center;
      a_tag    <= tag;
    end
    if (advance) begin
      results.new_value       <= avg;
      results.cell_converged  <= ok;
      results.last_of_sweep   <= a_tag.last;
      results.sweep_converged <= a_tag.last && acc_next;
    end
  end

endmodule

@@ rtl/core/jacobi_stencil_sweep_unit.sv @@
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep_unit
// One Jacobi sweep of the 5-point heat stencil over a streamed square grid.
// ----------------------------------------------------------------------------
// Old grid cells enter in raster order, boundary included, one per cycle; the
// unit takes a cell in every cycle in which the result register is free or
// being emptied. Each cell of row 2 or below that lies off the left and right
// boundary completes the stencil of the cell above it, via the sum and result
// registers. Two row memories with registered, prefetched reads hold the
// previous rows, so the next cell can follow at once. There is no clearing
// pass after reset. The user must write grid_size (clamped to 3..MAX_GRID)
// and convergence_threshold only while idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep_unit #(
  parameter int MAX_GRID    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [jss_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [jss_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  jss_cell_if.sink                             cells,
  jss_result_if.source                         results
);

  localparam int AW  = $clog2(MAX_GRID);
  localparam int NW  = $clog2(MAX_GRID + 1);
  localparam int GW  = jss_pkg::GRID_SIZE_WIDTH;
  localparam int XW  = (NW > GW) ? NW : GW;
  localparam int SW  = VALUE_WIDTH + 2;

  logic [GW-1:0]                         grid_size;
  logic [jss_pkg::THRESHOLD_WIDTH-1:0]   threshold;
  logic [AW-1:0]                         row;
  logic [AW-1:0]                         col;
  logic signed [VALUE_WIDTH-1:0]         west;

  logic [XW-1:0]                 gs_ext;
  logic [XW-1:0]                 n_wide;
  logic [NW-1:0]                 n;
  logic                          beyond;
  logic [AW-1:0]                 r;
  logic [AW-1:0]                 c;
  logic [NW-1:0]                 r_ext;
  logic [NW-1:0]                 c_ext;
  logic [NW-1:0]                 r_inc;
  logic [NW-1:0]                 c_inc;
  logic                          col_wrap;
  logic                          row_wrap;
  logic [AW-1:0]                 row_next;
  logic [AW-1:0]                 col_next;
  logic                          emit;
  logic                          accept;
  logic                          calc_ready;
  logic [AW-1:0]                 rd_col;
  jss_pkg::cell_tag_t            tag;
  logic signed [VALUE_WIDTH-1:0] north;
  logic signed [VALUE_WIDTH-1:0] center;
  logic signed [VALUE_WIDTH-1:0] east;
  logic signed [SW-1:0]          sum;

  // active grid side
  assign gs_ext = XW'(grid_size);
  assign n_wide = (gs_ext < XW'(jss_pkg::MIN_GRID)) ? XW'(jss_pkg::MIN_GRID) :
                  (gs_ext > XW'(MAX_GRID))          ? XW'(MAX_GRID) : gs_ext;
  assign n      = n_wide[NW-1:0];

  // position past a shrunk grid restarts the sweep
  assign beyond = (NW'(row) >= n) || (NW'(col) >= n);
  assign r      = beyond ? '0 : row;
  assign c      = beyond ? '0 : col;
  assign r_ext  = NW'(r);
  assign c_ext  = NW'(c);
  assign r_inc  = r_ext + 1'b1;
  assign c_inc  = c_ext + 1'b1;

  assign col_wrap = c_inc >= n;
  assign row_wrap = r_inc >= n;
  assign col_next = col_wrap ? '0 : c_inc[AW-1:0];
  assign row_next = col_wrap ? (row_wrap ? '0 : r_inc[AW-1:0]) : r;

  assign emit      = (r_ext >= NW'(2)) && (c_ext >= NW'(1)) && !col_wrap;
  assign tag.first = (r_ext == NW'(2)) && (c_ext == NW'(1));
  assign tag.last  = (r_ext == n - 1'b1) && (c_ext == n - NW'(2));

  assign cells.ready = calc_ready;
  assign accept      = cells.valid && cells.ready;
  assign rd_col      = accept ? col_next : c;

  assign sum = SW'(north) + SW'(cells.cell_value) + SW'(west) + SW'(east);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= jss_pkg::GRID_SIZE_RESET;
      threshold <= jss_pkg::THRESHOLD_RESET;
      row       <= '0;
      col       <= '0;
      west      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jss_pkg::REG_GRID_SIZE: grid_size <= cfg_data[GW-1:0];
          jss_pkg::REG_THRESHOLD: threshold <= cfg_data[jss_pkg::THRESHOLD_WIDTH-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        row  <= row_next;
        col  <= col_next;
        west <= center;
      end
    end
  end

  jss_line_buffer #(
    .MAX_GRID    (MAX_GRID),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .rd_col  (rd_col),
    .wr_en   (accept),
    .wr_col  (c),
    .wr_data (cells.cell_value),
    .north   (north),
    .center  (center),
    .east    (east)
  );

  jss_stencil_calc #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_stencil_calc (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emit),
    .ready     (calc_ready),
    .sum       (sum),
    .center    (center),
    .tag       (tag),
    .threshold (threshold),
    .results   (results)
  );

endmodule

@@ rtl/core/jss_checker.sv @@
// ----------------------------------------------------------------------------
// jss_checker
// Port-level checks of the sweep unit, bound to the top level.
// ----------------------------------------------------------------------------
module jss_checker (
  input logic clk,
  input logic rst,
  input logic cells_valid,
  input logic cells_ready,
  input logic results_valid,
  input logic results_ready,
  input logic cell_converged,
  input logic last_of_sweep,
  input logic sweep_converged
);

  // a waiting result transaction stays offered
  assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid)
    else $error("result dropped while stalled");

  // input backpressure only while a result waits
  assert property (@(posedge clk) disable iff (rst)
    !cells_ready |-> results_valid && !results_ready)
    else $error("input stalled without a waiting result");

  // sweep flag only on the last converged cell
  assert property (@(posedge clk) disable iff (rst)
    results_valid && sweep_converged |-> last_of_sweep && cell_converged)
    else $error("sweep_converged on a result that cannot carry it");

  // a fresh result follows a cell transaction
  assert property (@(posedge clk) disable iff (rst)
    $rose(results_valid) |-> $past(cells_valid && cells_ready, 2))
    else $error("result without a cell transaction");

endmodule

bind jacobi_stencil_sweep_unit jss_checker u_jss_checker (
  .clk             (clk),
  .rst             (rst),
  .cells_valid     (cells.valid),
  .cells_ready     (cells.ready),
  .results_valid   (results.valid),
  .results_ready   (results.ready),
  .cell_converged  (results.cell_converged),
  .last_of_sweep   (results.last_of_sweep),
  .sweep_converged (results.sweep_converged)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the Jacobi stencil sweep unit. Grid cells are
// streamed in raster order with random gaps while the result side stalls at
// random. A bit-accurate stencil predictor produces the expected results in
// order, and every result transaction is compared field by field. Grid sizes
// run from the clamped minimum to the clamped maximum, including shrinking
// the grid part way through a sweep.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_LIMIT     = 1024;
  localparam int DRAIN_CYCLES   = 6;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 350;
  localparam int PARTIAL_ROW    = 40;

  localparam logic [jss_pkg::CFG_INDEX_WIDTH-1:0] UNMAPPED_REG = 4'd9;
  localparam logic [31:0] VMAX    = 32'h7fff_ffff;
  localparam logic [31:0] VMIN    = 32'h8000_0000;
  localparam logic [30:0] EPS_MAX = 31'h7fff_ffff;

  typedef enum int {FILL_NOISE, FILL_SMOOTH, FILL_FLAT, FILL_RAILS} fill_mode_t;

  typedef struct packed {
    logic [31:0] new_value;
    logic        cell_converged;
    logic        last_of_sweep;
    logic        sweep_converged;
  } stencil_result_t;

  typedef struct packed {
    logic [31:0]     value;
    logic            typed;
    stencil_result_t want;
  } directed_row_t;

  localparam stencil_result_t NO_RESULT = '0;

  // three 3x3 sweeps: rails, negative rails, rounding toward minus infinity
  localparam directed_row_t DIRECTED_ROWS [27] = '{
    '{32'h0000_0000, 1'b0, NO_RESULT},
    '{VMAX,          1'b0, NO_RESULT},
    '{32'hffff_ffff, 1'b0, NO_RESULT},
    '{VMAX,          1'b0, NO_RESULT},
    '{VMIN,          1'b0, NO_RESULT},
    '{VMAX,          1'b0, NO_RESULT},
    '{32'h0001_0000, 1'b0, NO_RESULT},
    '{VMAX,          1'b1, '{VMAX, 1'b0, 1'b1, 1'b0}},
    '{32'h5555_5555, 1'b0, NO_RESULT},
    '{VMAX,          1'b0, NO_RESULT},
    '{VMIN,          1'b0, NO_RESULT},
    '{VMAX,          1'b0, NO_RESULT},
    '{VMIN,          1'b0, NO_RESULT},
    '{VMIN,          1'b0, NO_RESULT},
    '{VMIN,          1'b0, NO_RESULT},
    '{VMAX,          1'b0, NO_RESULT},
    '{VMIN,          1'b1, '{VMIN, 1'b1, 1'b1, 1'b1}},
    '{32'haaaa_aaaa, 1'b0, NO_RESULT},
    '{32'h1234_5678, 1'b0, NO_RESULT},
    '{32'hffff_ffff, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b0, NO_RESULT},
    '{32'hffff_ffff, 1'b0, NO_RESULT},
    '{32'hffff_ffff, 1'b0, NO_RESULT},
    '{32'hffff_ffff, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1, 1'b1, 1'b1}},
    '{32'h7fff_0000, 1'b0, NO_RESULT}
  };

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_we;
  logic [jss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [jss_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

  jss_cell_if   #(.VALUE_WIDTH(32)) cell_ch ();
  jss_result_if #(.VALUE_WIDTH(32)) result_ch ();

  jacobi_stencil_sweep_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cell_ch),
    .results   (result_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0]       above_row [GRID_LIMIT];
  logic [31:0]       prev_row [GRID_LIMIT];
  logic [31:0]       win_w, win_c, win_e;
  int unsigned       row_idx, col_idx;
  bit                sweep_ok;
  logic [10:0]       grid_reg;
  logic [30:0]       eps_reg;
  stencil_result_t   pending_results [$];
  int                error_count = 0;
  int                quiet_cycles = 0;
  bit                tx_gaps, rx_gaps, long_hold_pending;

  function automatic void model_reset();
    foreach (above_row[i]) begin
      above_row[i] = '0;
      prev_row[i]  = '0;
    end
    win_w    = '0;
    win_c    = '0;
    win_e    = '0;
    row_idx  = 0;
    col_idx  = 0;
    sweep_ok = 1'b1;
    grid_reg = jss_pkg::GRID_SIZE_RESET;
    eps_reg  = jss_pkg::THRESHOLD_RESET;
  endfunction

  function automatic int unsigned clamp_grid(input logic [10:0] raw);
    int unsigned n;
    n = raw;
    if (n < jss_pkg::MIN_GRID) n = jss_pkg::MIN_GRID;
    if (n > GRID_LIMIT) n = GRID_LIMIT;
    return n;
  endfunction

  function automatic bit sweep_open();
    int unsigned n;
    n = clamp_grid(grid_reg);
    return row_idx < n && col_idx < n && (row_idx != 0 || col_idx != 0);
  endfunction

  function automatic bit stencil_step(input logic [31:0] cell_in, output stencil_result_t res);
    int unsigned       n, r, c;
    logic [31:0]       north;
    logic signed [33:0] total;
    logic signed [31:0] avg;
    longint            delta;
    bit                ok, is_last, produced;
    n = clamp_grid(grid_reg);
    if (row_idx >= n || col_idx >= n) begin
      row_idx  = 0;
      col_idx  = 0;
      sweep_ok = 1'b1;
    end
    r = row_idx;
    c = col_idx;
    win_w = win_c;
    win_c = prev_row[c];
    win_e = (c + 1 < n) ? prev_row[c + 1] : '0;
    north = above_row[c];
    res = '0;
    produced = 1'b0;
    if (r >= 2 && c >= 1 && c + 1 < n) begin
      total = $signed(north) + $signed(cell_in) + $signed(win_w) + $signed(win_e);
      avg = total >>> 2;
      delta = longint'(avg) - longint'($signed(win_c));
      if (delta < 0) delta = -delta;
      ok = delta <= longint'(eps_reg);
      is_last = (r == n - 1) && (c == n - 2);
      sweep_ok = sweep_ok && ok;
      res.new_value       = avg;
      res.cell_converged  = ok;
      res.last_of_sweep   = is_last;
      res.sweep_converged = is_last && sweep_ok;
      produced = 1'b1;
    end
    above_row[c] = prev_row[c];
    prev_row[c]  = cell_in;
    if (c + 1 >= n) begin
      col_idx = 0;
      if (r + 1 >= n) begin
        row_idx  = 0;
        sweep_ok = 1'b1;
      end else begin
        row_idx = r + 1;
      end
    end else begin
      col_idx = c + 1;
    end
    return produced;
  endfunction

  function automatic logic [31:0] draw_cell(input fill_mode_t mode, input logic [31:0] base);
    case (mode)
      FILL_SMOOTH: return base + 32'($urandom_range(0, 511)) - 32'd256;
      FILL_FLAT:   return base;
      FILL_RAILS:  return $urandom_range(0, 1) ? VMAX - 32'($urandom_range(0, 3))
                                               : VMIN + 32'($urandom_range(0, 3));
      default:     return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [jss_pkg::CFG_INDEX_WIDTH-1:0] index,
                           input logic [jss_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == jss_pkg::REG_GRID_SIZE) grid_reg = data[10:0];
    else if (index == jss_pkg::REG_THRESHOLD) eps_reg = data;
  endtask

  // wait until every pending result is back and the pipeline has gone quiet
  task automatic settle();
    cell_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_cell(input logic [31:0] value, output bit produced,
                           output stencil_result_t predicted);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_ch.valid      <= 1'b1;
    cell_ch.cell_value <= value;
    do @(posedge clk); while (cell_ch.ready !== 1'b1);
    produced = stencil_step(value, predicted);
  endtask

  task automatic feed_cell(input logic [31:0] value);
    bit              produced;
    stencil_result_t predicted;
    send_cell(value, produced, predicted);
    if (produced) pending_results.push_back(predicted);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int              stall;
    stencil_result_t want;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_gaps ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected transaction, new_value %h", result_ch.new_value));
      end else begin
        want = pending_results.pop_front();
        if (result_ch.new_value !== want.new_value)
          report_error($sformatf("new_value %h, want %h", result_ch.new_value, want.new_value));
        if (result_ch.cell_converged !== want.cell_converged)
          report_error($sformatf("cell_converged %b, want %b",
                                 result_ch.cell_converged, want.cell_converged));
        if (result_ch.last_of_sweep !== want.last_of_sweep)
          report_error($sformatf("last_of_sweep %b, want %b",
                                 result_ch.last_of_sweep, want.last_of_sweep));
        if (result_ch.sweep_converged !== want.sweep_converged)
          report_error($sformatf("sweep_converged %b, want %b",
                                 result_ch.sweep_converged, want.sweep_converged));
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("** jacobi_stencil_sweep_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned     n, count, fed;
    logic [10:0]     size_raw;
    logic [30:0]     eps;
    logic [31:0]     base;
    fill_mode_t      mode;
    bit              produced;
    stencil_result_t predicted;

    model_reset();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    long_hold_pending = 1'b0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    cell_ch.valid      <= 1'b0;
    cell_ch.cell_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset grid size, start of the first row, no results
    repeat (PARTIAL_ROW) feed_cell($urandom);
    settle();

    // shrink below the minimum mid-sweep, position restarts
    write_reg(jss_pkg::REG_GRID_SIZE, {20'($urandom), 11'd2});
    write_reg(UNMAPPED_REG, 31'($urandom));
    foreach (DIRECTED_ROWS[i]) begin
      send_cell(DIRECTED_ROWS[i].value, produced, predicted);
      if (DIRECTED_ROWS[i].typed) pending_results.push_back(DIRECTED_ROWS[i].want);
      else if (produced) pending_results.push_back(predicted);
    end
    settle();

    // grid size above the maximum, zero threshold
    write_reg(jss_pkg::REG_GRID_SIZE, {20'($urandom), 11'd2047});
    write_reg(jss_pkg::REG_THRESHOLD, 31'd0);
    repeat (PARTIAL_ROW) feed_cell($urandom);
    settle();

    // back-pressure: result side holds off while cells keep coming
    tx_gaps = 1'b0;
    long_hold_pending = 1'b1;
    write_reg(jss_pkg::REG_GRID_SIZE, {20'($urandom), 11'd10});
    write_reg(jss_pkg::REG_THRESHOLD, 31'd655);
    base = $urandom;
    repeat (200) feed_cell(draw_cell(FILL_SMOOTH, base));
    settle();

    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       size_raw = 11'($urandom_range(0, 2));
        9:       size_raw = 11'($urandom_range(12, 20));
        default: size_raw = 11'($urandom_range(3, 9));
      endcase
      // growing the grid mid-sweep would read unwritten row entries
      if (sweep_open() && clamp_grid(size_raw) > clamp_grid(grid_reg))
        size_raw = 11'(clamp_grid(grid_reg));
      case ($urandom_range(0, 3))
        0:       eps = 31'd0;
        1:       eps = EPS_MAX;
        2:       eps = 31'($urandom_range(0, 1500));
        default: eps = 31'($urandom);
      endcase
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      mode = fill_mode_t'($urandom_range(0, 3));
      base = $urandom;
      write_reg(jss_pkg::REG_GRID_SIZE, {20'($urandom), size_raw});
      write_reg(jss_pkg::REG_THRESHOLD, eps);
      n = clamp_grid(size_raw);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, n * n - 1);
      else count = n * n * $urandom_range(1, 3);
      if (fed + count > RANDOM_ITEMS) count = RANDOM_ITEMS - fed;
      repeat (count) feed_cell(draw_cell(mode, base));
      fed += count;
      settle();
    end

    if (error_count == 0) begin
      $display("** jacobi_stencil_sweep_unit: PASSED **");
    end else begin
      $display("** jacobi_stencil_sweep_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/jss_pkg.sv
rtl/core/jss_stream_ifs.sv
rtl/core/jss_line_buffer.sv
rtl/core/jss_stencil_calc.sv
rtl/core/jacobi_stencil_sweep_unit.sv
rtl/core/jss_checker.sv
verif/tb_top.sv
